// ----- hdl/bls_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bls_pkg
// Shared types and constants for the bounded LIFO stack.
// ----------------------------------------------------------------------------
package bls_pkg;

    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int FILL_W = 7;
    localparam int WORD_W = 32;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic [ADDR_W-1:0]        t_addr;
    typedef logic [FILL_W-1:0]        t_fill;

    typedef enum logic [1:0] {
        CMD_PUSH = 2'd0,
        CMD_POP  = 2'd1,
        CMD_PEEK = 2'd2,
        CMD_DUMP = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_OVER  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_LOAD,
        S_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic    push;       // write entry at the top and grow
        logic    pop;        // shrink by one
        logic    set_ptr;    // point the read port at the top entry
        logic    dec_ptr;    // step the read port one entry down
        logic    load_out;   // capture a result word
        logic    from_mem;   // result value comes from the read port
        t_status status;
        logic    last;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
        logic ptr_zero;
    } t_dp_stat;

endpackage

// ----- hdl/bls_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bls_datapath
// Entry memory, fill counter, read pointer and result register.
// ----------------------------------------------------------------------------
module bls_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bls_pkg::t_dp_cmd   i_cmd,
    input  bls_pkg::t_word     i_push_value,
    output bls_pkg::t_dp_stat  o_stat,
    output bls_pkg::t_word     o_read_value,
    output bls_pkg::t_status   o_status,
    output bls_pkg::t_fill     o_fill_level,
    output logic               o_last
);
    import bls_pkg::*;

    t_word   r_mem [DEPTH];
    t_word   r_rdata;
    t_fill   r_count;
    t_fill   n_count;
    t_addr   r_ptr;
    t_addr   n_ptr;
    t_word   r_value;
    t_status r_status;
    t_fill   r_fill;
    logic    r_last;

    always_comb begin
        n_count = r_count;
        if (i_cmd.push) begin
            n_count = r_count + t_fill'(1);
        end else if (i_cmd.pop) begin
            n_count = r_count - t_fill'(1);
        end
    end

    always_comb begin
        n_ptr = r_ptr;
        if (i_cmd.set_ptr) begin
            n_ptr = t_addr'(r_count - t_fill'(1));
        end else if (i_cmd.dec_ptr) begin
            n_ptr = r_ptr - t_addr'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
    end

    // single write port at the top, registered read at the pointer
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[r_count[ADDR_W-1:0]] <= i_push_value;
        end
        r_rdata <= r_mem[r_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_value  <= i_cmd.from_mem ? r_rdata : '0;
            r_status <= i_cmd.status;
            r_fill   <= n_count;
            r_last   <= i_cmd.last;
        end
    end

    assign o_stat.empty    = (r_count == '0);
    assign o_stat.full     = (r_count == t_fill'(DEPTH));
    assign o_stat.ptr_zero = (r_ptr == '0);

    assign o_read_value = r_value;
    assign o_status     = r_status;
    assign o_fill_level = r_fill;
    assign o_last       = r_last;

endmodule

// ----- hdl/bls_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bls_ctrl
// Command sequencer: decodes each word, drives the datapath, paces results.
// ----------------------------------------------------------------------------
module bls_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  bls_pkg::t_cmd      i_cmd,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  bls_pkg::t_dp_stat  i_stat,
    output bls_pkg::t_dp_cmd   o_dp_cmd
);
    import bls_pkg::*;

    t_state r_state;
    t_state n_state;
    t_cmd   r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_cmd <= i_cmd;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_cmd == CMD_PUSH || i_stat.empty) begin
                        n_state = S_OUT;
                    end else begin
                        n_state = S_FETCH;
                    end
                end
            end
            S_FETCH: n_state = S_LOAD;
            S_LOAD:  n_state = S_OUT;
            S_OUT: begin
                if (i_out_ready) begin
                    if (r_cmd == CMD_DUMP && !i_stat.ptr_zero) begin
                        n_state = S_FETCH;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_dp_cmd    = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_dp_cmd.last = 1'b1;
                    if (i_cmd == CMD_PUSH) begin
                        o_dp_cmd.load_out = 1'b1;
                        if (i_stat.full) begin
                            o_dp_cmd.status = ST_OVER;
                        end else begin
                            o_dp_cmd.push   = 1'b1;
                            o_dp_cmd.status = ST_OK;
                        end
                    end else if (i_stat.empty) begin
                        o_dp_cmd.load_out = 1'b1;
                        o_dp_cmd.status   = ST_EMPTY;
                    end else begin
                        o_dp_cmd.set_ptr = 1'b1;
                        o_dp_cmd.pop     = (i_cmd == CMD_POP);
                    end
                end
            end
            S_LOAD: begin
                o_dp_cmd.load_out = 1'b1;
                o_dp_cmd.from_mem = 1'b1;
                o_dp_cmd.status   = ST_OK;
                o_dp_cmd.last     = (r_cmd != CMD_DUMP) || i_stat.ptr_zero;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                // advance to the next entry down while dumping
                if (i_out_ready && r_cmd == CMD_DUMP && !i_stat.ptr_zero) begin
                    o_dp_cmd.dec_ptr = 1'b1;
                end
            end
            default: begin
                o_dp_cmd = '0;
            end
        endcase
    end

endmodule

// ----- hdl/bounded_lifo_stack.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_lifo_stack
// Bounded LIFO stack of signed 32-bit words with push, pop, peek and dump.
// ----------------------------------------------------------------------------
// The stack takes one command word at a time and returns its results before
// it takes the next. Push, full or not, and any other command that finds the
// stack empty, shows its result in the cycle after acceptance. Pop and peek
// set the read pointer on acceptance, read the entry memory through its
// registered port in the fetch state, load the result register in the load
// state and show it in the out state. Dump walks the entries top to bottom
// this way, one memory read per result, stepping the pointer down as each
// word is taken. The input is ready again in the cycle after the last result
// is taken. The 64-word entry memory needs no clearing after reset.
module bounded_lifo_stack (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  bls_pkg::t_cmd     i_cmd,
    input  bls_pkg::t_word    i_push_value,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output bls_pkg::t_word    o_read_value,
    output bls_pkg::t_status  o_status,
    output bls_pkg::t_fill    o_fill_level,
    output logic              o_last
);
    import bls_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    bls_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cmd       (i_cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (dp_stat),
        .o_dp_cmd    (dp_cmd)
    );

    bls_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .i_push_value (i_push_value),
        .o_stat       (dp_stat),
        .o_read_value (o_read_value),
        .o_status     (o_status),
        .o_fill_level (o_fill_level),
        .o_last       (o_last)
    );

endmodule
